[rtl/core/vms_pkg.sv]
// Vault memory command sequencer: shared types and constants.
// State encoding, request modes, strobe masks and the sequencer state record.
// No dependencies.
`timescale 1ns / 1ps

package vms_pkg;

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_CPY  = 4'd1,
    ST_CS   = 4'd2,
    ST_RAS  = 4'd3,
    ST_CAS  = 4'd4,
    ST_OE   = 4'd5,
    ST_WE   = 4'd6,
    ST_EXEC = 4'd7,
    ST_TSV  = 4'd8,
    ST_DONE = 4'd9
  } vms_fsm_e;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PIM   = 2'd2,
    MODE_NONE  = 2'd3
  } vms_mode_e;

  localparam int unsigned CmdBits   = 7;
  localparam int unsigned PopBits   = 3;
  localparam int unsigned StbBits   = CmdBits + PopBits;
  localparam int unsigned CountBits = 6;

  typedef logic [StbBits-1:0] vms_stb_t;

  // bits 0..6 command strobes, 7..9 pop strobes
  localparam vms_stb_t StbCs      = 10'h001;
  localparam vms_stb_t StbRas     = 10'h002;
  localparam vms_stb_t StbCas     = 10'h004;
  localparam vms_stb_t StbWe      = 10'h008;
  localparam vms_stb_t StbOe      = 10'h010;
  localparam vms_stb_t StbExec    = 10'h020;
  localparam vms_stb_t StbDone    = 10'h040;
  localparam vms_stb_t StbPopReq  = 10'h080;
  localparam vms_stb_t StbPopBank = 10'h100;
  localparam vms_stb_t StbPopPim  = 10'h200;
  localparam vms_stb_t StbCmdMask = 10'h07f;

  localparam logic [15:0] OffsetStep = 16'd2;

  typedef struct packed {
    vms_fsm_e              fsm;
    vms_fsm_e              prior;
    logic [CountBits-1:0]  xfer_cnt;
    logic [1:0]            op;
    logic [3:0]            size;
    logic [15:0]           run_off;
    logic [3:0]            bank;
    logic [31:0]           addr;
    logic [3:0]            pim_op;
    logic [15:0]           pim_off;
    vms_stb_t              stb;
    logic [15:0]           out_off;
  } vms_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  size;
    logic [15:0] offset;
    logic [3:0]  bank;
    logic [31:0] address;
    logic [3:0]  pim_op;
    logic        tsv_ack;
    logic        rsp_sent;
  } vms_req_t;

endpackage

[rtl/core/vms_step.sv]
// Vault memory command sequencer: next-state logic for one sequencer step.
// Pure combinational transition of the sequencer record. Depends on vms_pkg.
`timescale 1ns / 1ps

module vms_step (
  input  vms_pkg::vms_state_t                  state_i,
  input  vms_pkg::vms_req_t                    req_i,
  input  logic [vms_pkg::CountBits-1:0]        xfer_need_i,
  output vms_pkg::vms_state_t                  state_o
);
  import vms_pkg::*;

  logic loop_done;

  assign loop_done = (state_i.xfer_cnt == xfer_need_i);

  always_comb begin
    state_o = state_i;
    unique case (state_i.fsm) inside
      ST_IDLE: begin
        state_o.prior    = ST_IDLE;
        state_o.stb      = state_i.stb & StbOe;   // oe is left alone here
        state_o.xfer_cnt = '0;
        state_o.fsm      = (vms_mode_e'(req_i.mode) != MODE_NONE) ? ST_CPY : ST_IDLE;
      end
      ST_CPY: begin
        state_o.prior   = ST_CPY;
        state_o.op      = req_i.mode;
        state_o.size    = req_i.size;
        state_o.run_off = req_i.offset;
        state_o.bank    = req_i.bank;
        state_o.addr    = req_i.address;
        state_o.pim_off = req_i.offset;
        state_o.pim_op  = req_i.pim_op;
        state_o.out_off = req_i.offset;
        state_o.stb     = (state_i.stb & StbCmdMask) | StbPopReq;
        state_o.fsm     = ST_CS;
      end
      ST_CS: begin
        state_o.prior = ST_CS;
        state_o.stb   = (state_i.stb & StbPopPim) | StbCs;
        state_o.fsm   = ST_RAS;
      end
      ST_RAS: begin
        state_o.prior = ST_RAS;
        state_o.stb   = StbRas;
        state_o.fsm   = ST_CAS;
      end
      ST_CAS: begin
        state_o.prior = ST_CAS;
        state_o.stb   = StbCas;
        // a captured "none" mode has no successor: stay in CAS
        if (vms_mode_e'(state_i.op) == MODE_READ || vms_mode_e'(state_i.op) == MODE_PIM) begin
          state_o.fsm = ST_OE;
        end else if (vms_mode_e'(state_i.op) == MODE_WRITE) begin
          state_o.fsm = ST_WE;
        end
      end
      ST_OE, ST_WE: begin
        state_o.prior = state_i.fsm;
        state_o.stb   = '0;
        if (loop_done) begin
          if (state_i.fsm == ST_WE || vms_mode_e'(state_i.op) == MODE_READ) begin
            state_o.fsm = ST_DONE;
          end else begin
            state_o.fsm = ST_EXEC;
          end
        end else begin
          state_o.out_off  = state_i.run_off;
          state_o.run_off  = state_i.run_off + OffsetStep;
          state_o.xfer_cnt = state_i.xfer_cnt + CountBits'(1);
          state_o.fsm      = ST_TSV;
        end
      end
      ST_EXEC: begin
        state_o.stb      = StbExec | StbPopPim;
        state_o.xfer_cnt = '0;
        state_o.fsm      = ST_WE;
      end
      ST_TSV: begin
        if (state_i.prior == ST_WE) begin
          state_o.stb = (state_i.stb & ~StbCmdMask) | StbWe;
          if (req_i.tsv_ack) begin
            state_o.stb = (state_i.stb & ~StbCmdMask) | StbWe | StbPopBank;
            state_o.fsm = ST_WE;
          end
        end else if (state_i.prior == ST_OE) begin
          state_o.stb = (state_i.stb & ~StbCmdMask) | StbOe;
          if (req_i.tsv_ack) begin
            state_o.fsm = ST_OE;
          end
        end
      end
      ST_DONE: begin
        state_o.prior = ST_DONE;
        state_o.stb   = (state_i.stb & (StbPopReq | StbPopBank)) | StbDone;
        state_o.fsm   = req_i.rsp_sent ? ST_IDLE : ST_DONE;
      end
      default: begin
        state_o.fsm = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/vault_memory_command_sequencer_top.sv]
// Vault memory command sequencer top: stream ports, state and result registers.
// A result word is registered and appears in the cycle after its input word is accepted.
// One word per cycle while the output is not stalled; the output register frees input ready when taken.
// Transfer count per loop comes from a 16-entry table built from LINK_WIDTH.
// Reset (async, active low): sequencer IDLE, state zero; result data not reset.
`timescale 1ns / 1ps

module vault_memory_command_sequencer_top #(
  parameter int unsigned LINK_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] req_size, [19:4] req_offset, [23:20] req_bank, [55:24] req_address,
  // [59:56] req_pim_op, [60] tsv_ack, [61] rsp_sent, [63:62] unused
  input  logic [63:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] command_strobes, [9:7] pop_strobes, [11:10] op_out, [43:12] row_addr,
  // [47:44] bank_out, [63:48] xfer_off, [67:64] pim_op_out,
  // [83:68] pim_base, [87:84] zero
  output logic [87:0] m_axis_tdata
);
  import vms_pkg::*;

  logic [CountBits-1:0] xfer_tab [16];

  for (genvar g = 0; g < 16; g++) begin : g_xfer
    // ceil((g+1)*16 / LINK_WIDTH), worked out at elaboration
    assign xfer_tab[g] = CountBits'(((g + 1) * 16 + LINK_WIDTH - 1) / LINK_WIDTH);
  end

  vms_state_t state_q, state_d;
  vms_req_t   req;
  logic       in_fire;
  logic       out_valid_q, out_valid_d;
  logic [87:0] out_data_q, out_data_d;
  logic [CountBits-1:0] xfer_need;

  assign req.mode     = s_axis_tuser;
  assign req.size     = s_axis_tdata[3:0];
  assign req.offset   = s_axis_tdata[19:4];
  assign req.bank     = s_axis_tdata[23:20];
  assign req.address  = s_axis_tdata[55:24];
  assign req.pim_op   = s_axis_tdata[59:56];
  assign req.tsv_ack  = s_axis_tdata[60];
  assign req.rsp_sent = s_axis_tdata[61];

  assign xfer_need = xfer_tab[state_q.size];

  vms_step u_step (
    .state_i     (state_q),
    .req_i       (req),
    .xfer_need_i (xfer_need),
    .state_o     (state_d)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign out_valid_d = in_fire || (out_valid_q && !m_axis_tready);
  assign out_data_d  = {4'b0000, state_d.pim_off, state_d.pim_op, state_d.out_off,
                        state_d.bank, state_d.addr, state_d.op, state_d.stb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.fsm      <= ST_IDLE;
      state_q.prior    <= ST_IDLE;
      state_q.xfer_cnt <= '0;
      state_q.op       <= '0;
      state_q.size     <= '0;
      state_q.run_off  <= '0;
      state_q.bank     <= '0;
      state_q.addr     <= '0;
      state_q.pim_op   <= '0;
      state_q.pim_off  <= '0;
      state_q.stb      <= '0;
      state_q.out_off  <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // EXEC is only entered from a finished PIM-mode OE loop and keeps prior state
  a_exec_prior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fsm == ST_EXEC |-> state_q.prior == ST_OE)
    else $error("EXEC without a preceding OE loop");

  a_tsv_prior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fsm == ST_TSV |-> (state_q.prior == ST_OE || state_q.prior == ST_WE))
    else $error("link wait entered from outside a transfer loop");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.xfer_cnt <= xfer_need)
    else $error("transfer count ran past the loop length");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> out_valid_q && $stable(state_q))
    else $error("sequencer advanced while a result was stalled");

endmodule
